### hw/rtl/tkl_pkg.sv
`timescale 1ns / 1ps

package tkl_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_READ   = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_DROP  = 2'd2
	} status_t;

	localparam int unsigned TAG_W   = 16;
	localparam int unsigned SIZE_W  = 64;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned COUNT_W = 7;

	typedef struct packed {
		kind_t               kind;
		logic [TAG_W-1:0]    tag;
		logic [SIZE_W-1:0]   size;
		logic [INDEX_W-1:0]  index;
	} req_word_t;

	typedef struct packed {
		status_t             status;
		logic [TAG_W-1:0]    read_tag;
		logic [SIZE_W-1:0]   read_size;
		logic [COUNT_W-1:0]  entry_count;
	} rsp_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;
	} dp_cmd_t;

endpackage

### hw/rtl/top_k_largest_tracker.sv
`timescale 1ns / 1ps

// Channel   Payload                 Handshake
// req       tkl_pkg::req_word_t     req_valid / req_stall
// rsp       tkl_pkg::rsp_word_t     rsp_valid / rsp_stall
//
// Each word is accepted, executed against all list cells in parallel, and
// its result is registered at the same edge.
// One word per cycle is sustained while rsp is not stalled; the combinational
// compare across all cells sets the clock period.
// Reset clears the entry count and the result register; the list starts empty.
// req_stall is high only while an untaken result is stalled at rsp.

module top_k_largest_tracker #(
	parameter int unsigned LIST_DEPTH = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  tkl_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output tkl_pkg::rsp_word_t rsp
);

	tkl_pkg::dp_cmd_t cmd;

	tkl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	tkl_datapath #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.rsp       (rsp)
	);

endmodule

### hw/rtl/tkl_ctrl.sv
`timescale 1ns / 1ps

module tkl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output tkl_pkg::dp_cmd_t    cmd
);

	typedef enum logic {
		ST_EMPTY,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic   accept;

	// The result register frees up in the same cycle that its word is taken.
	assign req_stall = (state_q == ST_HOLD) && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign cmd.exec  = accept;
	assign rsp_valid = (state_q == ST_HOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			case (state_q)
				ST_EMPTY: begin
					if (accept) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!accept && !rsp_stall) begin
						state_q <= ST_EMPTY;
					end
				end
				default: begin
					state_q <= ST_EMPTY;
				end
			endcase
		end
	end

endmodule

### hw/rtl/tkl_datapath.sv
`timescale 1ns / 1ps

module tkl_datapath #(
	parameter int unsigned LIST_DEPTH = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tkl_pkg::dp_cmd_t    cmd,
	input  tkl_pkg::req_word_t  req,
	output tkl_pkg::rsp_word_t  rsp
);

	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
	localparam int unsigned IW = $clog2(LIST_DEPTH);

	logic [tkl_pkg::SIZE_W-1:0] size_q [LIST_DEPTH];
	logic [tkl_pkg::TAG_W-1:0]  tag_q  [LIST_DEPTH];
	logic [CW-1:0]              count_q;
	tkl_pkg::rsp_word_t         rsp_q;

	logic [LIST_DEPTH-1:0] valid_v;
	logic [LIST_DEPTH-1:0] ge_v;
	logic [LIST_DEPTH-1:0] at_last_v;
	logic [LIST_DEPTH-1:0] place_v;
	logic [LIST_DEPTH-1:0] before_v;
	logic                  full;
	logic                  append;
	logic                  kept;
	logic                  read_ok;
	logic [IW-1:0]         rd_idx;
	logic                  rd_hit;
	logic [CW-1:0]         count_d;
	tkl_pkg::rsp_word_t    rsp_d;

	// Every cell compares against the incoming size at once; the insert
	// position is the first cell that claims it, and all cells past it
	// take their upper neighbor.
	always_comb begin
		full = (count_q == CW'(LIST_DEPTH));
		for (int i = 0; i < LIST_DEPTH; i++) begin
			valid_v[i]   = (CW'(i) < count_q);
			ge_v[i]      = valid_v[i] && (req.size >= size_q[i]);
			at_last_v[i] = (CW'(i + 1) == count_q) && (req.size <= size_q[i]);
		end
		append = !full && ((count_q == '0) || (|at_last_v));
		for (int i = 0; i < LIST_DEPTH; i++) begin
			place_v[i]  = append ? (CW'(i) == count_q) : ge_v[i];
			before_v[i] = |(place_v & ~({LIST_DEPTH{1'b1}} << i));
		end
		kept = |place_v;

		read_ok = ({1'b0, req.index} < (tkl_pkg::INDEX_W + 1)'(LIST_DEPTH));
		rd_idx  = req.index[IW-1:0];
		rd_hit  = read_ok && valid_v[rd_idx];

		count_d = count_q;
		rsp_d   = '0;
		case (req.kind)
			tkl_pkg::KIND_INSERT: begin
				if (!kept) begin
					rsp_d.status = tkl_pkg::STATUS_DROP;
				end else if (!full) begin
					count_d = count_q + CW'(1);
				end
			end
			tkl_pkg::KIND_READ: begin
				if (!read_ok) begin
					rsp_d.status = tkl_pkg::STATUS_RANGE;
				end else if (rd_hit) begin
					rsp_d.read_tag  = tag_q[rd_idx];
					rsp_d.read_size = size_q[rd_idx];
				end
			end
			tkl_pkg::KIND_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
		rsp_d.entry_count = tkl_pkg::COUNT_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// Cells past the count are never read as data, so clear only drops the
	// count and the cell contents need no reset.
	always_ff @(posedge clk) begin
		if (cmd.exec && (req.kind == tkl_pkg::KIND_INSERT)) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				if (before_v[i] && (i > 0)) begin
					size_q[i] <= size_q[(i > 0) ? i - 1 : 0];
					tag_q[i]  <= tag_q[(i > 0) ? i - 1 : 0];
				end else if (place_v[i]) begin
					size_q[i] <= req.size;
					tag_q[i]  <= req.tag;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_q <= '0;
		end else if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

### hw/rtl/tkl_checker.sv
`timescale 1ns / 1ps

module tkl_checker #(
	parameter int unsigned LIST_DEPTH = 20
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input tkl_pkg::req_word_t req,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input tkl_pkg::rsp_word_t rsp
);

	// A stalled result word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed");

	// Every accepted word produces a result in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted word produced no result");

	// No new word is taken while a result is stuck.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("word accepted over a stalled result");

	// The count never passes the list depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.entry_count <= tkl_pkg::COUNT_W'(LIST_DEPTH)))
		else $error("entry count above list depth");

	// A clear leaves an empty list and a plain ok.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.kind == tkl_pkg::KIND_CLEAR)
		|=> (rsp.entry_count == '0) && (rsp.status == tkl_pkg::STATUS_OK))
		else $error("clear did not empty the list");

endmodule

bind top_k_largest_tracker tkl_checker #(
	.LIST_DEPTH (LIST_DEPTH)
) u_tkl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
